@@ rtl/copolymer_growth_monte_carlo_step_macros.svh @@
// ----------------------------------------------------------------------------
// Copolymer growth step - assertion macros
// Concurrent checks sampled on i_clk, switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COPOLYMER_GROWTH_MONTE_CARLO_STEP_MACROS_SVH
`define COPOLYMER_GROWTH_MONTE_CARLO_STEP_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent holds -> consequent holds in the same cycle
`define CGMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the following cycle
`define CGMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CGMC_ASSERT_IMP(lbl, ante, cons, msg)
`define CGMC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/cgmc_pkg.sv @@
// ----------------------------------------------------------------------------
// cgmc_pkg
// Shared widths, codes and types of the copolymer growth step.
// ----------------------------------------------------------------------------
package cgmc_pkg;

    // field widths
    localparam int RATE_W    = 24;
    localparam int DRAW_W    = 16;
    localparam int KIND_W    = 2;
    localparam int TRANS_W   = 3;
    localparam int LEN_OUT_W = 12;
    localparam int FRAC_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_RATES = 8;

    // rate sum of up to three rates, and draw times sum
    localparam int AB_W  = RATE_W + 1;
    localparam int SUM_W = RATE_W + 2;
    localparam int LHS_W = DRAW_W + SUM_W;

    // one quotient bit per divider step
    localparam int DIV_STEPS = FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [RATE_W-1:0] RATE_RESET = 24'h01_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FWD_RR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_RW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_WW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_WR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_RR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_RW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_WR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_WW = 3'd7;

    typedef enum logic [KIND_W-1:0] {
        MOVE_ADD_RIGHT = 2'd0,
        MOVE_ADD_WRONG = 2'd1,
        MOVE_POP       = 2'd2,
        MOVE_REFUSED   = 2'd3
    } t_move;

    typedef enum logic [TRANS_W-1:0] {
        TR_RR_FWD  = 3'd0,
        TR_RW_FWD  = 3'd1,
        TR_WW_FWD  = 3'd2,
        TR_WR_FWD  = 3'd3,
        TR_RR_BACK = 3'd4,
        TR_RW_BACK = 3'd5,
        TR_WR_BACK = 3'd6,
        TR_WW_BACK = 3'd7
    } t_trans;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/cgmc_frac_div.sv @@
// ----------------------------------------------------------------------------
// cgmc_frac_div
// Restoring divider for wrong * 65536 / length, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cgmc_frac_div #(
    parameter int LW = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [LW-1:0]                 i_wrong,
    input  logic [LW-1:0]                 i_len,
    output cgmc_pkg::t_div_stat           o_stat,
    output logic [cgmc_pkg::FRAC_W-1:0]   o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [cgmc_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [LW-1:0]                     r_rem;
    logic [LW-1:0]                     r_den;
    logic [cgmc_pkg::FRAC_W-1:0]       r_num;

    logic [LW:0]                       w_sh;
    logic [LW:0]                       w_diff;
    logic                              w_ge;

    // shift in the next dividend bit and try the subtract
    assign w_sh   = {r_rem, r_num[cgmc_pkg::FRAC_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});

    // Dividend is wrong << 16 and the quotient is at most 65536, so the
    // first 17 bits of the long division start from wrong >> 1 (< length).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= cgmc_pkg::DIV_CNT_W'(cgmc_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - cgmc_pkg::DIV_CNT_W'(1);
                if (r_cnt == cgmc_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_wrong >> 1;
            r_den <= i_len;
            r_num <= {i_wrong[0], {(cgmc_pkg::FRAC_W-1){1'b0}}};
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[LW-1:0] : w_sh[LW-1:0];
            r_num <= {r_num[cgmc_pkg::FRAC_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_num;

endmodule

@@ rtl/copolymer_growth_monte_carlo_step.sv @@
// ----------------------------------------------------------------------------
// copolymer_growth_monte_carlo_step
// One Monte Carlo step of a two-monomer chain held on a stack per input word.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-----------------------------------
//  input    | i_in_valid   | o_in_stall   | i_random_draw
//  output   | o_out_valid  | i_out_stall  | o_move_kind .. o_chain_full
//  config   | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
//  A growth step runs from acceptance to result through two chain reads,
//  rate select, sum, multiply, decide, then 17 divider steps and a hand-off.
//  A refused step (chain full) skips the front and goes straight to the divider.
//  Most of a step is spent in the 17-step fraction divider.
//  No clearing pass after reset: the chain store is read only below its length.
//  o_in_stall is high from acceptance until the result is loaded; a stalled
//  result holds in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`include "copolymer_growth_monte_carlo_step_macros.svh"

module copolymer_growth_monte_carlo_step #(
    parameter int MAX_LENGTH = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [cgmc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cgmc_pkg::RATE_W-1:0]         i_cfg_data,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [cgmc_pkg::DRAW_W-1:0]         i_random_draw,
    // result words
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [cgmc_pkg::KIND_W-1:0]         o_move_kind,
    output logic [cgmc_pkg::TRANS_W-1:0]        o_transition_used,
    output logic [cgmc_pkg::LEN_OUT_W-1:0]      o_chain_length,
    output logic [cgmc_pkg::FRAC_W-1:0]         o_wrong_fraction,
    output logic                                o_chain_full
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int LW = $clog2(MAX_LENGTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_BELOW,
        S_SEL,
        S_SUM,
        S_MUL,
        S_DECIDE,
        S_DIV,
        S_DONE
    } t_state;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state                              r_state;
    logic [cgmc_pkg::RATE_W-1:0]         r_rate [0:cgmc_pkg::NUM_RATES-1];
    logic                                r_chain [0:MAX_LENGTH-1];
    logic                                r_mem_q;

    logic [LW-1:0]                       r_len;
    logic [LW-1:0]                       r_wrong;
    logic [cgmc_pkg::DRAW_W-1:0]         r_draw;
    logic                                r_top;
    logic                                r_can_pop;
    logic [cgmc_pkg::RATE_W-1:0]         r_a;
    logic [cgmc_pkg::AB_W-1:0]           r_ab;
    logic [cgmc_pkg::RATE_W-1:0]         r_back;
    logic [cgmc_pkg::SUM_W-1:0]          r_sum;
    logic [cgmc_pkg::LHS_W-1:0]          r_lhs;
    logic                                r_bit_a;
    logic                                r_bit_b;
    cgmc_pkg::t_trans                    r_tr_a;
    cgmc_pkg::t_trans                    r_tr_b;
    cgmc_pkg::t_trans                    r_tr_back;
    cgmc_pkg::t_move                     r_kind;
    cgmc_pkg::t_trans                    r_trans;

    logic                                r_o_valid;
    cgmc_pkg::t_move                     r_o_kind;
    cgmc_pkg::t_trans                    r_o_trans;
    logic [cgmc_pkg::LEN_OUT_W-1:0]      r_o_len;
    logic [cgmc_pkg::FRAC_W-1:0]         r_o_frac;
    logic                                r_o_full;

    // ------------------------------------------------------------------
    // combinational
    // ------------------------------------------------------------------
    logic                                w_in_acc;
    logic                                w_full;
    logic [LW-1:0]                       w_len_m1;
    logic [LW-1:0]                       w_len_m2;
    logic [AW-1:0]                       w_rd_addr;
    logic                                w_below;

    logic [cgmc_pkg::RATE_W-1:0]         w_a;
    logic [cgmc_pkg::RATE_W-1:0]         w_b;
    logic [cgmc_pkg::RATE_W-1:0]         w_back;
    logic                                w_bit_a;
    logic                                w_bit_b;
    cgmc_pkg::t_trans                    w_tr_a;
    cgmc_pkg::t_trans                    w_tr_b;
    cgmc_pkg::t_trans                    w_tr_back;
    logic [cgmc_pkg::LHS_W-1:0]          w_prod;

    logic                                w_lt_a;
    logic                                w_lt_ab;
    logic                                w_pop;
    logic                                w_push_bit;
    logic [LW-1:0]                       n_len;
    logic [LW-1:0]                       n_wrong;
    cgmc_pkg::t_move                     n_kind;
    cgmc_pkg::t_trans                    n_trans;

    logic                                w_div_start;
    logic [LW-1:0]                       w_div_wrong;
    logic [LW-1:0]                       w_div_len;
    cgmc_pkg::t_div_stat                 w_div;
    logic [cgmc_pkg::FRAC_W-1:0]         w_quot;
    logic                                w_out_free;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_full     = (r_len >= LW'(MAX_LENGTH));
    assign w_out_free = !r_o_valid || !i_out_stall;

    // chain store read addresses: top, then the monomer below it
    assign w_len_m1  = r_len - LW'(1);
    assign w_len_m2  = r_len - LW'(2);
    assign w_rd_addr = (r_state == S_RD_BELOW) ? w_len_m2[AW-1:0] : w_len_m1[AW-1:0];

    // bottom entry is always right; it is never written
    assign w_below = (r_len >= LW'(3)) ? r_mem_q : 1'b0;

    // rate and transition selection from the top pair
    always_comb begin
        if (!r_top) begin
            w_a = r_rate[cgmc_pkg::REG_FWD_RR]; w_bit_a = 1'b0; w_tr_a = cgmc_pkg::TR_RR_FWD;
            w_b = r_rate[cgmc_pkg::REG_FWD_RW]; w_bit_b = 1'b1; w_tr_b = cgmc_pkg::TR_RW_FWD;
        end else if (!r_can_pop) begin
            w_a = r_rate[cgmc_pkg::REG_FWD_WW]; w_bit_a = 1'b1; w_tr_a = cgmc_pkg::TR_WW_FWD;
            w_b = r_rate[cgmc_pkg::REG_FWD_WR]; w_bit_b = 1'b0; w_tr_b = cgmc_pkg::TR_WR_FWD;
        end else begin
            w_a = r_rate[cgmc_pkg::REG_FWD_WR]; w_bit_a = 1'b0; w_tr_a = cgmc_pkg::TR_WR_FWD;
            w_b = r_rate[cgmc_pkg::REG_FWD_WW]; w_bit_b = 1'b1; w_tr_b = cgmc_pkg::TR_WW_FWD;
        end

        unique case ({w_below, r_top})
            2'b00: begin
                w_back = r_rate[cgmc_pkg::REG_BACK_RR]; w_tr_back = cgmc_pkg::TR_RR_BACK;
            end
            2'b01: begin
                w_back = r_rate[cgmc_pkg::REG_BACK_RW]; w_tr_back = cgmc_pkg::TR_RW_BACK;
            end
            2'b10: begin
                w_back = r_rate[cgmc_pkg::REG_BACK_WR]; w_tr_back = cgmc_pkg::TR_WR_BACK;
            end
            default: begin
                w_back = r_rate[cgmc_pkg::REG_BACK_WW]; w_tr_back = cgmc_pkg::TR_WW_BACK;
            end
        endcase
        // no backward move at length one
        if (!r_can_pop) begin
            w_back = '0;
        end
    end

    // draw times rate sum
    assign w_prod = r_draw * r_sum;

    // threshold compares and next chain state
    assign w_lt_a  = (r_lhs < {2'b00, r_a, 16'h0000});
    assign w_lt_ab = (r_lhs < {1'b0, r_ab, 16'h0000});
    assign w_pop   = !w_lt_a && r_can_pop && !w_lt_ab;

    always_comb begin
        w_push_bit = w_lt_a ? r_bit_a : r_bit_b;
        if (w_pop) begin
            n_len   = w_len_m1;
            n_wrong = r_wrong - LW'(r_top);
            n_kind  = cgmc_pkg::MOVE_POP;
            n_trans = r_tr_back;
        end else begin
            n_len   = r_len + LW'(1);
            n_wrong = r_wrong + LW'(w_push_bit);
            n_kind  = w_push_bit ? cgmc_pkg::MOVE_ADD_WRONG : cgmc_pkg::MOVE_ADD_RIGHT;
            n_trans = w_lt_a ? r_tr_a : r_tr_b;
        end
    end

    // divider launch: refused steps use the unchanged state
    assign w_div_start = (r_state == S_DECIDE) || (w_in_acc && w_full);
    assign w_div_wrong = (r_state == S_DECIDE) ? n_wrong : r_wrong;
    assign w_div_len   = (r_state == S_DECIDE) ? n_len   : r_len;

    cgmc_frac_div #(
        .LW (LW)
    ) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_wrong (w_div_wrong),
        .i_len   (w_div_len),
        .o_stat  (w_div),
        .o_quot  (w_quot)
    );

    // ------------------------------------------------------------------
    // rate registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cgmc_pkg::NUM_RATES; i++) begin
                r_rate[i] <= cgmc_pkg::RATE_RESET;
            end
        end else if (i_cfg_we) begin
            r_rate[i_cfg_idx] <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // chain store: one write, one registered read
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DECIDE) && !w_pop) begin
            r_chain[r_len[AW-1:0]] <= w_push_bit;
        end
        r_mem_q <= r_chain[w_rd_addr];
    end

    // ------------------------------------------------------------------
    // sequencer, chain state and result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= LW'(1);
            r_wrong   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // taken word leaves unless a new one is loaded below
            if (r_o_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_draw <= i_random_draw;
                        if (w_full) begin
                            r_kind  <= cgmc_pkg::MOVE_REFUSED;
                            r_trans <= cgmc_pkg::TR_RR_FWD;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_RD_TOP;
                        end
                    end
                end
                S_RD_TOP: begin
                    r_can_pop <= (r_len >= LW'(2));
                    r_state   <= S_RD_BELOW;
                end
                S_RD_BELOW: begin
                    r_top   <= (w_len_m1 == '0) ? 1'b0 : r_mem_q;
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_a       <= w_a;
                    r_ab      <= cgmc_pkg::AB_W'(w_a) + cgmc_pkg::AB_W'(w_b);
                    r_back    <= w_back;
                    r_bit_a   <= w_bit_a;
                    r_bit_b   <= w_bit_b;
                    r_tr_a    <= w_tr_a;
                    r_tr_b    <= w_tr_b;
                    r_tr_back <= w_tr_back;
                    r_state   <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= cgmc_pkg::SUM_W'(r_ab) + cgmc_pkg::SUM_W'(r_back);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_lhs   <= w_prod;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_len   <= n_len;
                    r_wrong <= n_wrong;
                    r_kind  <= n_kind;
                    r_trans <= n_trans;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= r_kind;
                        r_o_trans <= r_trans;
                        r_o_len   <= cgmc_pkg::LEN_OUT_W'(r_len);
                        r_o_frac  <= w_quot;
                        r_o_full  <= (r_len == LW'(MAX_LENGTH));
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_move_kind       = r_o_kind;
    assign o_transition_used = r_o_trans;
    assign o_chain_length    = r_o_len;
    assign o_wrong_fraction  = r_o_frac;
    assign o_chain_full      = r_o_full;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `CGMC_ASSERT_IMP(a_wrong_below_len, 1'b1, r_wrong < r_len, "wrong count too high")
    `CGMC_ASSERT_IMP(a_len_range, 1'b1, (r_len != '0) && (r_len <= LW'(MAX_LENGTH)), "bad length")
    `CGMC_ASSERT_IMP(a_div_in_state, w_div.done, r_state == S_DIV, "divider finished outside wait")
    `CGMC_ASSERT_IMP(a_div_running, (r_state == S_DIV) && !w_div.done, w_div.busy, "divider idle")
    `CGMC_ASSERT_NXT(a_accept_stalls, w_in_acc, o_in_stall, "input taken while step under way")

endmodule

@@ bench/copolymer_growth_monte_carlo_step_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// copolymer_growth_monte_carlo_step_test
// Self-checking bench for the copolymer growth step. A table of directed
// draws covers every transition, length one, zero and maximum rates. Random
// draws then run under a series of rate settings, with idle and stall bursts
// on both channels. A growth phase with no removal lengthens the chain, a
// phase with zero forward rates pops it back down. Every result word is
// compared field by field against a behavioural model of the chain or, for pinned rows, a hand-worked value.
// ----------------------------------------------------------------------------
module copolymer_growth_monte_carlo_step_test;

    localparam int MAX_LEN    = 2048;
    localparam int LIMIT      = 1_000_000;
    localparam int END_TAIL   = 40;
    localparam int PRINT_CAP  = 100;
    localparam int RAND_SETS  = 8;
    localparam int RAND_WORDS = 80;
    localparam int GROW_WORDS = 150;
    localparam int POP_WORDS  = 60;
    localparam int LAST_WORDS = 130;
    localparam logic [cgmc_pkg::RATE_W-1:0] RATE_MAX = '1;
    localparam logic [cgmc_pkg::DRAW_W-1:0] DRAW_CORNERS [8] = '{
        16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'hFFFE, 16'hFFFF
    };

    typedef struct packed {
        cgmc_pkg::t_move                  kind;
        cgmc_pkg::t_trans                 trans;
        logic [cgmc_pkg::LEN_OUT_W-1:0]   len;
        logic [cgmc_pkg::FRAC_W-1:0]      frac;
        logic                             full;
    } t_step_result;

    // one directed step; new_rates writes rate_all to every register first
    typedef struct packed {
        logic                             new_rates;
        logic [cgmc_pkg::RATE_W-1:0]      rate_all;
        logic [cgmc_pkg::DRAW_W-1:0]      draw;
        logic                             pinned;
        t_step_result                     want;
    } t_row;

    localparam t_step_result UNPINNED = '0;
    localparam int N_ROWS = 22;

    // pinned rows are worked out by hand from the decision rule
    t_row directed_rows [N_ROWS] = '{
        // reset rates, length one and two
        '{1'b0, cgmc_pkg::RATE_RESET, 16'h0000, 1'b1,
          '{cgmc_pkg::MOVE_ADD_RIGHT, cgmc_pkg::TR_RR_FWD, 12'd2, 17'd0, 1'b0}},
        '{1'b0, cgmc_pkg::RATE_RESET, 16'hFFFF, 1'b1,
          '{cgmc_pkg::MOVE_POP, cgmc_pkg::TR_RR_BACK, 12'd1, 17'd0, 1'b0}},
        '{1'b0, cgmc_pkg::RATE_RESET, 16'hFFFF, 1'b1,
          '{cgmc_pkg::MOVE_ADD_WRONG, cgmc_pkg::TR_RW_FWD, 12'd2, 17'd32768, 1'b0}},
        '{1'b0, cgmc_pkg::RATE_RESET, 16'h0000, 1'b1,
          '{cgmc_pkg::MOVE_ADD_RIGHT, cgmc_pkg::TR_WR_FWD, 12'd3, 17'd21845, 1'b0}},
        '{1'b0, cgmc_pkg::RATE_RESET, 16'hFFFF, 1'b1,
          '{cgmc_pkg::MOVE_POP, cgmc_pkg::TR_WR_BACK, 12'd2, 17'd32768, 1'b0}},
        '{1'b0, cgmc_pkg::RATE_RESET, 16'h8000, 1'b1,
          '{cgmc_pkg::MOVE_ADD_WRONG, cgmc_pkg::TR_WW_FWD, 12'd3, 17'd43690, 1'b0}},
        '{1'b0, cgmc_pkg::RATE_RESET, 16'hFFFF, 1'b1,
          '{cgmc_pkg::MOVE_POP, cgmc_pkg::TR_WW_BACK, 12'd2, 17'd32768, 1'b0}},
        '{1'b0, cgmc_pkg::RATE_RESET, 16'hFFFF, 1'b1,
          '{cgmc_pkg::MOVE_POP, cgmc_pkg::TR_RW_BACK, 12'd1, 17'd0, 1'b0}},
        // zero rate sum: second forward choice at length one, removal above
        '{1'b1, 24'h000000, 16'h0000, 1'b1,
          '{cgmc_pkg::MOVE_ADD_WRONG, cgmc_pkg::TR_RW_FWD, 12'd2, 17'd32768, 1'b0}},
        '{1'b0, 24'h000000, 16'h1234, 1'b1,
          '{cgmc_pkg::MOVE_POP, cgmc_pkg::TR_RW_BACK, 12'd1, 17'd0, 1'b0}},
        '{1'b0, 24'h000000, 16'hFFFF, 1'b1,
          '{cgmc_pkg::MOVE_ADD_WRONG, cgmc_pkg::TR_RW_FWD, 12'd2, 17'd32768, 1'b0}},
        '{1'b0, 24'h000000, 16'h0000, 1'b1,
          '{cgmc_pkg::MOVE_POP, cgmc_pkg::TR_RW_BACK, 12'd1, 17'd0, 1'b0}},
        // maximum rates
        '{1'b1, RATE_MAX, 16'h0000, 1'b1,
          '{cgmc_pkg::MOVE_ADD_RIGHT, cgmc_pkg::TR_RR_FWD, 12'd2, 17'd0, 1'b0}},
        '{1'b0, RATE_MAX, 16'hFFFF, 1'b0, UNPINNED},
        '{1'b0, RATE_MAX, 16'h8000, 1'b0, UNPINNED},
        '{1'b0, RATE_MAX, 16'h5555, 1'b0, UNPINNED},
        '{1'b0, RATE_MAX, 16'hAAAA, 1'b0, UNPINNED},
        '{1'b0, RATE_MAX, 16'h0001, 1'b0, UNPINNED},
        '{1'b0, RATE_MAX, 16'hFFFE, 1'b0, UNPINNED},
        '{1'b0, RATE_MAX, 16'h7FFF, 1'b0, UNPINNED},
        '{1'b0, RATE_MAX, 16'h2AAA, 1'b0, UNPINNED},
        '{1'b1, cgmc_pkg::RATE_RESET, 16'h4000, 1'b0, UNPINNED}
    };

    // clock, reset and block inputs
    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               cfg_we       = 1'b0;
    logic [cgmc_pkg::CFG_IDX_W-1:0]     cfg_idx      = '0;
    logic [cgmc_pkg::RATE_W-1:0]        cfg_data     = '0;
    logic                               in_valid     = 1'b0;
    logic [cgmc_pkg::DRAW_W-1:0]        random_draw  = '0;
    logic                               out_stall    = 1'b0;

    // side information travelling with the input word
    logic                               pinned       = 1'b0;
    t_step_result                       pinned_want  = '0;

    // block outputs
    logic                               o_in_stall;
    logic                               o_out_valid;
    logic [cgmc_pkg::KIND_W-1:0]        o_move_kind;
    logic [cgmc_pkg::TRANS_W-1:0]       o_transition_used;
    logic [cgmc_pkg::LEN_OUT_W-1:0]     o_chain_length;
    logic [cgmc_pkg::FRAC_W-1:0]        o_wrong_fraction;
    logic                               o_chain_full;

    // chain model and rates
    logic                               chain_store [MAX_LEN];
    int                                 chain_len;
    int                                 wrong_total;
    logic [cgmc_pkg::RATE_W-1:0]        rate      [cgmc_pkg::NUM_RATES];
    logic [cgmc_pkg::RATE_W-1:0]        rate_plan [cgmc_pkg::NUM_RATES];

    t_step_result                       expected_q [$];
    logic                               idle_on     = 1'b1;
    int                                 stall_left  = 0;
    int                                 cycles      = 0;
    int                                 fail_count  = 0;
    int                                 words_seen  = 0;
    int                                 settings    = 0;
    int                                 longest     = 1;
    int                                 kind_tally  [4];
    int                                 trans_tally [cgmc_pkg::NUM_RATES];

    copolymer_growth_monte_carlo_step #(
        .MAX_LENGTH (MAX_LEN)
    ) u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_random_draw     (random_draw),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_move_kind       (o_move_kind),
        .o_transition_used (o_transition_used),
        .o_chain_length    (o_chain_length),
        .o_wrong_fraction  (o_wrong_fraction),
        .o_chain_full      (o_chain_full)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, expected_q.size());
            $display("** copolymer_growth_monte_carlo_step: FAILED **");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        if (fail_count < PRINT_CAP)
            $display("[%0t] %s", $realtime, msg);
        fail_count++;
    endtask

    // One step of the chain: decide the move from the draw, update the stack
    function automatic t_step_result grow_step(input logic [cgmc_pkg::DRAW_W-1:0] draw);
        t_step_result      res;
        logic [63:0]       fa, fb, bk, lhs;
        cgmc_pkg::t_move   mv_a, mv_b;
        cgmc_pkg::t_trans  tr_a, tr_b, tr_bk;
        logic              top, below, poppable;
        res = '0;
        if (chain_len >= MAX_LEN) begin
            res.kind  = cgmc_pkg::MOVE_REFUSED;
            res.trans = cgmc_pkg::TR_RR_FWD;
        end else begin
            top      = chain_store[chain_len-1];
            poppable = (chain_len >= 2);
            below    = poppable ? chain_store[chain_len-2] : 1'b0;
            // bottom monomer is always right, so a wrong top implies length two or more
            if (!top) begin
                fa = 64'(rate[cgmc_pkg::REG_FWD_RR]);
                mv_a = cgmc_pkg::MOVE_ADD_RIGHT; tr_a = cgmc_pkg::TR_RR_FWD;
                fb = 64'(rate[cgmc_pkg::REG_FWD_RW]);
                mv_b = cgmc_pkg::MOVE_ADD_WRONG; tr_b = cgmc_pkg::TR_RW_FWD;
            end else begin
                fa = 64'(rate[cgmc_pkg::REG_FWD_WR]);
                mv_a = cgmc_pkg::MOVE_ADD_RIGHT; tr_a = cgmc_pkg::TR_WR_FWD;
                fb = 64'(rate[cgmc_pkg::REG_FWD_WW]);
                mv_b = cgmc_pkg::MOVE_ADD_WRONG; tr_b = cgmc_pkg::TR_WW_FWD;
            end
            bk    = '0;
            tr_bk = cgmc_pkg::TR_RR_BACK;
            if (poppable) begin
                case ({below, top})
                    2'b00: begin
                        bk = 64'(rate[cgmc_pkg::REG_BACK_RR]); tr_bk = cgmc_pkg::TR_RR_BACK;
                    end
                    2'b01: begin
                        bk = 64'(rate[cgmc_pkg::REG_BACK_RW]); tr_bk = cgmc_pkg::TR_RW_BACK;
                    end
                    2'b10: begin
                        bk = 64'(rate[cgmc_pkg::REG_BACK_WR]); tr_bk = cgmc_pkg::TR_WR_BACK;
                    end
                    default: begin
                        bk = 64'(rate[cgmc_pkg::REG_BACK_WW]); tr_bk = cgmc_pkg::TR_WW_BACK;
                    end
                endcase
            end
            // compare u * S against the scaled partial sums
            lhs = 64'(draw) * (fa + fb + bk);
            if (lhs < (fa << 16)) begin
                res.kind  = mv_a;
                res.trans = tr_a;
            end else if (!poppable || lhs < ((fa + fb) << 16)) begin
                res.kind  = mv_b;
                res.trans = tr_b;
            end else begin
                res.kind  = cgmc_pkg::MOVE_POP;
                res.trans = tr_bk;
            end
            if (res.kind == cgmc_pkg::MOVE_POP) begin
                if (top)
                    wrong_total--;
                chain_len--;
            end else begin
                chain_store[chain_len] = (res.kind == cgmc_pkg::MOVE_ADD_WRONG);
                chain_len++;
                if (res.kind == cgmc_pkg::MOVE_ADD_WRONG)
                    wrong_total++;
            end
        end
        res.len  = cgmc_pkg::LEN_OUT_W'(chain_len);
        res.frac = cgmc_pkg::FRAC_W'((longint'(wrong_total) << 16) / chain_len);
        res.full = (chain_len == MAX_LEN);
        if (chain_len > longest)
            longest = chain_len;
        return res;
    endfunction

    // predict on every accepted input word
    always @(posedge clk) begin
        t_step_result res;
        t_step_result want;
        if (rst_n && in_valid && !o_in_stall) begin
            res  = grow_step(random_draw);
            want = pinned ? pinned_want : res;
            expected_q = {expected_q, want};
        end
    end

    // check every accepted result word against the oldest expectation
    always @(posedge clk) begin
        t_step_result want;
        if (rst_n && o_out_valid && !out_stall) begin
            words_seen++;
            if (expected_q.size() == 0) begin
                flag_error($sformatf("word %0d: result with nothing expected", words_seen));
            end else begin
                want = expected_q.pop_front();
                if (o_move_kind !== want.kind)
                    flag_error($sformatf("word %0d: move_kind %0d, expected %0d",
                                         words_seen, o_move_kind, want.kind));
                if (o_transition_used !== want.trans)
                    flag_error($sformatf("word %0d: transition_used %0d, expected %0d",
                                         words_seen, o_transition_used, want.trans));
                if (o_chain_length !== want.len)
                    flag_error($sformatf("word %0d: chain_length %0d, expected %0d",
                                         words_seen, o_chain_length, want.len));
                if (o_wrong_fraction !== want.frac)
                    flag_error($sformatf("word %0d: wrong_fraction %0d, expected %0d",
                                         words_seen, o_wrong_fraction, want.frac));
                if (o_chain_full !== want.full)
                    flag_error($sformatf("word %0d: chain_full %0d, expected %0d",
                                         words_seen, o_chain_full, want.full));
                kind_tally[want.kind]++;
                if (want.kind != cgmc_pkg::MOVE_REFUSED)
                    trans_tally[want.trans]++;
            end
        end
    end

    // receiver stall bursts
    always @(posedge clk) begin
        if (!rst_n || !idle_on) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 19) - 1;
        end else begin
            out_stall  <= 1'b0;
        end
    end

    // present one draw, with an optional idle burst first; returns on acceptance
    task automatic send_draw(input logic [cgmc_pkg::DRAW_W-1:0] draw, input logic pin,
                             input t_step_result want);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        random_draw <= draw;
        pinned      <= pin;
        pinned_want <= want;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
    endtask

    // hold off the sender until every expected word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    // write rate_plan into all registers; block must be idle
    task automatic load_rates();
        for (int i = 0; i < cgmc_pkg::NUM_RATES; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= cgmc_pkg::CFG_IDX_W'(i);
            cfg_data <= rate_plan[i];
            @(posedge clk);
            rate[i] = rate_plan[i];
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [cgmc_pkg::DRAW_W-1:0] pick_draw();
        if ($urandom_range(0, 4) == 0)
            return DRAW_CORNERS[$urandom_range(0, 7)];
        return cgmc_pkg::DRAW_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [cgmc_pkg::RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RATE_MAX;
            2:       return cgmc_pkg::RATE_RESET;
            3, 4:    return cgmc_pkg::RATE_W'($urandom_range(0, 16'hFFFF));
            default: return cgmc_pkg::RATE_W'($urandom_range(0, RATE_MAX));
        endcase
    endfunction

    initial begin
        int trans_hit;
        // model state after reset
        foreach (rate[i]) rate[i] = cgmc_pkg::RATE_RESET;
        chain_store[0] = 1'b0;
        chain_len      = 1;
        wrong_total    = 0;
        foreach (kind_tally[i]) kind_tally[i] = 0;
        foreach (trans_tally[i]) trans_tally[i] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].new_rates) begin
                drain_results();
                foreach (rate_plan[i]) rate_plan[i] = directed_rows[r].rate_all;
                load_rates();
            end
            send_draw(directed_rows[r].draw, directed_rows[r].pinned, directed_rows[r].want);
        end

        // random draws under a series of random rate settings
        for (int p = 0; p < RAND_SETS; p++) begin
            drain_results();
            idle_on <= ($urandom_range(0, 3) != 0);
            foreach (rate_plan[i]) rate_plan[i] = pick_rate();
            load_rates();
            repeat (RAND_WORDS) send_draw(pick_draw(), 1'b0, UNPINNED);
        end

        // grow the chain: no removal, every forward rate non-zero
        drain_results();
        idle_on <= 1'b1;
        foreach (rate_plan[i])
            rate_plan[i] = (i < 4) ? cgmc_pkg::RATE_W'($urandom_range(1, RATE_MAX)) : '0;
        load_rates();
        repeat (GROW_WORDS) send_draw(pick_draw(), 1'b0, UNPINNED);

        // forward rates zero: every step removes the top
        drain_results();
        foreach (rate_plan[i]) rate_plan[i] = (i < 4) ? '0 : pick_rate();
        load_rates();
        repeat (POP_WORDS) send_draw(pick_draw(), 1'b0, UNPINNED);

        // last stretch with neither side idling
        drain_results();
        idle_on <= 1'b0;
        foreach (rate_plan[i]) rate_plan[i] = pick_rate();
        load_rates();
        repeat (LAST_WORDS) send_draw(pick_draw(), 1'b0, UNPINNED);

        drain_results();
        repeat (END_TAIL) @(posedge clk);
        if (expected_q.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", expected_q.size()));

        trans_hit = 0;
        foreach (trans_tally[i]) trans_hit += (trans_tally[i] != 0);
        $display("%0d steps checked: %0d right added, %0d wrong added, %0d removed, %0d refused",
                 words_seen, kind_tally[cgmc_pkg::MOVE_ADD_RIGHT],
                 kind_tally[cgmc_pkg::MOVE_ADD_WRONG], kind_tally[cgmc_pkg::MOVE_POP],
                 kind_tally[cgmc_pkg::MOVE_REFUSED]);
        $display("%0d of 8 transitions used, longest chain %0d, %0d rate settings, %0d errors",
                 trans_hit, longest, settings, fail_count);
        if (fail_count == 0)
            $display("** copolymer_growth_monte_carlo_step: PASSED **");
        else
            $display("** copolymer_growth_monte_carlo_step: FAILED **");
        $finish;
    end

endmodule
